// ===== hdl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, operation codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int POOL_WORDS   = 4096;
   localparam int HEADER_BYTES = 4;
   localparam int HDR_SPAN     = ((HEADER_BYTES + 3) / 4) * 4;
   localparam int ADDR_W       = $clog2(POOL_WORDS);
   localparam int POOL_BYTES   = POOL_WORDS * 4;
   localparam int HDR_W        = 16;
   localparam int DIVD_W       = 22;
   localparam int DIVS_W       = 15;

   localparam logic [2:0] MODE_FORMAT = 3'd0;
   localparam logic [2:0] MODE_ALLOC  = 3'd1;
   localparam logic [2:0] MODE_FREE   = 3'd2;
   localparam logic [2:0] MODE_DEFRAG = 3'd3;
   localparam logic [2:0] MODE_REPORT = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_ZERO  = 2'd2;

   localparam logic CSR_POOL_BYTES    = 1'b0;
   localparam logic CSR_MERGE_ON_FREE = 1'b1;

   typedef struct packed {
      logic load;
      logic fmt;
      logic off_zero;
      logic off_next;
      logic off_absn;
      logic rd_off;
      logic rd_abs;
      logic alloc_eval;
      logic wr_used;
      logic wr_clear;
      logic abs_start;
      logic abs_merge;
      logic stat_acc;
      logic div_start_u;
      logic div_start_f;
      logic pct_u_load;
      logic pct_f_load;
      logic set_nofit;
      logic set_zero;
      logic rsp_load;
   } ffha_cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       req_zero;
      logic       formatted;
      logic       rel_ok;
      logic       merge;
      logic       used;
      logic       fits;
      logic       at_end;
      logic       hit;
      logic       past;
      logic       abs_end;
      logic       fb_zero;
      logic       div_busy;
      logic       div_done;
   } ffha_stat_type;

endpackage

// ===== hdl/ffha_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ffha_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ffha_div import ffha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVS_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/ffha_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator datapath
// Header memory, chain walk arithmetic, statistics and result registers.
// ----------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic [14:0]   csr_write_data,
   input  logic [2:0]    req_mode,
   input  logic [14:0]   req_request_bytes,
   input  logic [13:0]   req_release_offset,
   input  ffha_cmd_type  cmd,
   output ffha_stat_type stat,
   output logic [1:0]    rsp_status,
   output logic [13:0]   rsp_data_offset,
   output logic [14:0]   rsp_free_bytes,
   output logic [14:0]   rsp_largest_free,
   output logic [12:0]   rsp_free_blocks,
   output logic [12:0]   rsp_used_blocks,
   output logic [6:0]    rsp_percent_used,
   output logic [6:0]    rsp_percent_fragmented
);

   localparam logic [16:0] HDR17  = 17'(HDR_SPAN);
   localparam logic [16:0] POOL17 = 17'(POOL_BYTES);

   logic [14:0] pool_bytes_ff;
   logic        merge_ff;
   logic [14:0] total_ff;
   logic        formatted_ff;

   logic [2:0]  mode_ff;
   logic [15:0] sz_ff;
   logic [13:0] rel_ff;
   logic [13:0] off_ff;
   logic [13:0] head_ff;
   logic [14:0] hsize_ff;
   logic [14:0] alloc_sz_ff;

   logic [1:0]  res_status_ff;
   logic [13:0] res_doff_ff;
   logic [14:0] fb_ff, big_ff;
   logic [12:0] cf_ff, cu_ff;
   logic [6:0]  pu_ff, pf_ff;

   logic [HDR_W-1:0]  rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [HDR_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr;

   logic [14:0] rsize;
   logic        used;
   logic [16:0] next_n, abs_n, split_off, diff, p_round, p_fmt;
   logic [15:0] sz_tmp;
   logic [13:0] target;
   logic [14:0] merged;

   logic [DIVD_W-1:0] div_dividend, div_q;
   logic [DIVS_W-1:0] div_divisor;
   logic              div_busy, div_done;

   assign rsize     = rd_data[14:0];
   assign used      = rd_data[15];
   assign next_n    = 17'(off_ff) + HDR17 + 17'(rsize);
   assign abs_n     = 17'(head_ff) + HDR17 + 17'(hsize_ff);
   assign split_off = 17'(off_ff) + HDR17 + 17'(sz_ff);
   assign diff      = 17'(rsize) - 17'(sz_ff);
   assign target    = 14'(rel_ff - 14'(HDR_SPAN));
   assign merged    = 15'(hsize_ff + rsize + 15'(HDR_SPAN));
   assign sz_tmp    = 16'(req_request_bytes) + 16'd3;

   // Pool size is rounded down to a word and saturated to one header .. full pool.
   always_comb begin
      p_round = {2'b00, pool_bytes_ff[14:2], 2'b00};
      p_fmt   = p_round;
      if (p_round > POOL17) begin
         p_fmt = POOL17;
      end
      if (p_round < HDR17) begin
         p_fmt = HDR17;
      end
   end

   always_comb begin
      stat.mode      = mode_ff;
      stat.req_zero  = (sz_ff == 16'd0);
      stat.formatted = formatted_ff;
      stat.rel_ok    = (rel_ff >= 14'(HDR_SPAN));
      stat.merge     = merge_ff;
      stat.used      = used;
      stat.fits      = !used && (16'(rsize) >= sz_ff);
      stat.at_end    = (next_n + HDR17) >= 17'(total_ff);
      stat.hit       = (off_ff == target);
      stat.past      = (off_ff > target);
      stat.abs_end   = (abs_n + HDR17) >= 17'(total_ff);
      stat.fb_zero   = (fb_ff == 15'd0);
      stat.div_busy  = div_busy;
      stat.div_done  = div_done;
   end

   // Header memory write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = off_ff[ADDR_W+1:2];
      wr_data = '0;
      if (cmd.fmt) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = {1'b0, 15'(p_fmt - HDR17)};
      end else if (cmd.alloc_eval) begin
         wr_en   = (diff > HDR17);
         wr_addr = split_off[ADDR_W+1:2];
         wr_data = {1'b0, 15'(diff - HDR17)};
      end else if (cmd.wr_used) begin
         wr_data = {1'b1, alloc_sz_ff};
         wr_en   = 1'b1;
      end else if (cmd.wr_clear) begin
         wr_en   = 1'b1;
         wr_data = {1'b0, rsize};
      end else if (cmd.abs_merge) begin
         wr_en   = 1'b1;
         wr_addr = head_ff[ADDR_W+1:2];
         wr_data = {1'b0, merged};
      end
   end

   assign rd_addr = cmd.rd_abs ? abs_n[ADDR_W+1:2] : off_ff[ADDR_W+1:2];

   ffha_ram #(
      .WIDTH (HDR_W),
      .DEPTH (POOL_WORDS)
   ) u_header_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_off | cmd.rd_abs),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign div_dividend = cmd.div_start_u ? DIVD_W'(fb_ff * 22'd100)
                                         : DIVD_W'(big_ff * 22'd100);
   assign div_divisor  = cmd.div_start_u ? total_ff : fb_ff;

   ffha_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start_u | cmd.div_start_f),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_bytes_ff <= 15'd16384;
         merge_ff      <= 1'b1;
         total_ff      <= '0;
         formatted_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_POOL_BYTES:    pool_bytes_ff <= csr_write_data;
               CSR_MERGE_ON_FREE: merge_ff      <= csr_write_data[0];
               default:           ;
            endcase
         end
         if (cmd.fmt) begin
            total_ff     <= 15'(p_fmt);
            formatted_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff       <= req_mode;
         sz_ff         <= {sz_tmp[15:2], 2'b00};
         rel_ff        <= req_release_offset;
         res_status_ff <= STATUS_OK;
         res_doff_ff   <= '0;
         fb_ff         <= '0;
         big_ff        <= '0;
         cf_ff         <= '0;
         cu_ff         <= '0;
         pu_ff         <= '0;
         pf_ff         <= '0;
      end
      if (cmd.off_zero) off_ff <= '0;
      if (cmd.off_next) off_ff <= next_n[13:0];
      if (cmd.off_absn) off_ff <= abs_n[13:0];
      if (cmd.alloc_eval) begin
         alloc_sz_ff <= (diff > HDR17) ? sz_ff[14:0] : rsize;
      end
      if (cmd.wr_used) res_doff_ff <= 14'(off_ff + 14'(HDR_SPAN));
      if (cmd.wr_clear || cmd.abs_start) begin
         head_ff  <= off_ff;
         hsize_ff <= rsize;
      end
      if (cmd.abs_merge) hsize_ff <= merged;
      if (cmd.stat_acc) begin
         if (used) begin
            cu_ff <= cu_ff + 13'd1;
         end else begin
            cf_ff <= cf_ff + 13'd1;
            fb_ff <= fb_ff + rsize;
            if (rsize > big_ff) big_ff <= rsize;
         end
      end
      if (cmd.pct_u_load) pu_ff <= 7'd100 - div_q[6:0];
      if (cmd.pct_f_load) pf_ff <= 7'd100 - div_q[6:0];
      if (cmd.set_nofit) res_status_ff <= STATUS_NOFIT;
      if (cmd.set_zero)  res_status_ff <= STATUS_ZERO;
      if (cmd.rsp_load) begin
         rsp_status             <= res_status_ff;
         rsp_data_offset        <= res_doff_ff;
         rsp_free_bytes         <= fb_ff;
         rsp_largest_free       <= big_ff;
         rsp_free_blocks        <= cf_ff;
         rsp_used_blocks        <= cu_ff;
         rsp_percent_used       <= pu_ff;
         rsp_percent_fragmented <= pf_ff;
      end
   end

endmodule

// ===== hdl/ffha_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the chain walk for each mode and owns the channel handshakes.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  ffha_stat_type stat,
   output ffha_cmd_type  cmd
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_DISPATCH  = 11'b00000000010,
      S_READ      = 11'b00000000100,
      S_EVAL      = 11'b00000001000,
      S_ALLOC_WR  = 11'b00000010000,
      S_ABS_CHK   = 11'b00000100000,
      S_ABS_EVAL  = 11'b00001000000,
      S_DIV_START = 11'b00010000000,
      S_DIV_U     = 11'b00100000000,
      S_DIV_F     = 11'b01000000000,
      S_DONE      = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (stat.mode) inside
               MODE_FORMAT: cmd.fmt = 1'b1;
               MODE_ALLOC: begin
                  if (stat.req_zero) begin
                     cmd.set_zero = 1'b1;
                  end else if (!stat.formatted) begin
                     cmd.set_nofit = 1'b1;
                  end else begin
                     cmd.off_zero = 1'b1;
                     state_in     = S_READ;
                  end
               end
               MODE_FREE: begin
                  if (stat.formatted && stat.rel_ok) begin
                     cmd.off_zero = 1'b1;
                     state_in     = S_READ;
                  end
               end
               MODE_DEFRAG, MODE_REPORT: begin
                  if (stat.formatted) begin
                     cmd.off_zero = 1'b1;
                     state_in     = S_READ;
                  end
               end
               default: ;
            endcase
         end
         S_READ: begin
            cmd.rd_off = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_DONE;
            case (stat.mode)
               MODE_ALLOC: begin
                  if (stat.fits) begin
                     cmd.alloc_eval = 1'b1;
                     state_in       = S_ALLOC_WR;
                  end else if (stat.at_end) begin
                     cmd.set_nofit = 1'b1;
                  end else begin
                     cmd.off_next = 1'b1;
                     state_in     = S_READ;
                  end
               end
               MODE_FREE: begin
                  if (stat.hit) begin
                     cmd.wr_clear = 1'b1;
                     if (stat.merge) state_in = S_ABS_CHK;
                  end else if (!stat.past && !stat.at_end) begin
                     cmd.off_next = 1'b1;
                     state_in     = S_READ;
                  end
               end
               MODE_DEFRAG: begin
                  if (!stat.used) begin
                     cmd.abs_start = 1'b1;
                     state_in      = S_ABS_CHK;
                  end else if (!stat.at_end) begin
                     cmd.off_next = 1'b1;
                     state_in     = S_READ;
                  end
               end
               default: begin
                  cmd.stat_acc = 1'b1;
                  if (stat.at_end) begin
                     state_in = S_DIV_START;
                  end else begin
                     cmd.off_next = 1'b1;
                     state_in     = S_READ;
                  end
               end
            endcase
         end
         S_ALLOC_WR: begin
            cmd.wr_used = 1'b1;
            state_in    = S_DONE;
         end
         S_ABS_CHK: begin
            if (stat.abs_end) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_abs = 1'b1;
               state_in   = S_ABS_EVAL;
            end
         end
         S_ABS_EVAL: begin
            if (!stat.used) begin
               cmd.abs_merge = 1'b1;
               state_in      = S_ABS_CHK;
            end else if (stat.mode == MODE_DEFRAG) begin
               cmd.off_absn = 1'b1;
               state_in     = S_READ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV_START: begin
            cmd.div_start_u = 1'b1;
            state_in        = S_DIV_U;
         end
         S_DIV_U: begin
            if (stat.div_done) begin
               cmd.pct_u_load = 1'b1;
               if (stat.fb_zero) begin
                  state_in = S_DONE;
               end else begin
                  cmd.div_start_f = 1'b1;
                  state_in        = S_DIV_F;
               end
            end
         end
         S_DIV_F: begin
            if (stat.div_done) begin
               cmd.pct_f_load = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an untaken transaction");

   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_EVAL))
      else $error("header read not followed by evaluation");

   a_div_not_busy: assert property (@(posedge clock) disable iff (reset)
      stat.div_busy |-> !(cmd.div_start_u || cmd.div_start_f))
      else $error("divider restarted while busy");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// ===== hdl/first_fit_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Block chain allocator with format, allocate, free, defragment and report.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req_* carries a mode, a byte count for
// allocate and a data offset for free. Every request yields exactly one
// response transaction on rsp_* with a status, the allocated data offset
// and, for a report, the pool statistics.
// Requests are taken one at a time; req_stall is high while a request is
// being worked on. Each request walks the block chain through a header
// memory with one write and one read port, addressing the header of each
// visited block and then evaluating it. Each merged block adds another
// address and evaluate step, and an allocate that fits adds a write step.
// A report of a formatted pool adds one division, and a second when any byte is free.
// A block takes at least eight bytes, so the chain holds at most 2048 blocks.
// The response sits in an output register, so a stalled receiver does not
// block the walk; only the final load waits until the register is free.
// Reset returns the controller to idle, sets the configuration registers to
// their defaults and marks the pool unformatted; the header memory is not
// cleared, and a format request must run before the pool is used.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit import ffha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [14:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [14:0] req_request_bytes,
   input  logic [13:0] req_release_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_data_offset,
   output logic [14:0] rsp_free_bytes,
   output logic [14:0] rsp_largest_free,
   output logic [12:0] rsp_free_blocks,
   output logic [12:0] rsp_used_blocks,
   output logic [6:0]  rsp_percent_used,
   output logic [6:0]  rsp_percent_fragmented
);

   // The controller only issues commands; all storage and arithmetic sit in
   // the datapath, which reports back through the status struct.
   ffha_cmd_type  cmd;
   ffha_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_mode               (req_mode),
      .req_request_bytes      (req_request_bytes),
      .req_release_offset     (req_release_offset),
      .cmd                    (cmd),
      .stat                   (stat),
      .rsp_status             (rsp_status),
      .rsp_data_offset        (rsp_data_offset),
      .rsp_free_bytes         (rsp_free_bytes),
      .rsp_largest_free       (rsp_largest_free),
      .rsp_free_blocks        (rsp_free_blocks),
      .rsp_used_blocks        (rsp_used_blocks),
      .rsp_percent_used       (rsp_percent_used),
      .rsp_percent_fragmented (rsp_percent_fragmented)
   );

endmodule

// ===== test/first_fit_heap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives format, allocate, free, defragment and report transactions under
// several pool sizes and merge settings. A model of the block chain inside
// the bench predicts every response, and each response is compared field by
// field in order of arrival.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_tb;
   import ffha_pkg::*;

   // Modes 5 to 7 are not defined and must answer with all fields zero.
   localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
   localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
   localparam int unsigned USED_FLAG = 32'h8000_0000;
   localparam int unsigned SIZE_BITS = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] data_offset;
      logic [14:0] free_bytes;
      logic [14:0] largest_free;
      logic [12:0] free_blocks;
      logic [12:0] used_blocks;
      logic [6:0]  percent_used;
      logic [6:0]  percent_fragmented;
   } alloc_rsp_t;

   typedef struct packed {
      logic [2:0]  mode;
      logic [14:0] bytes;
      logic [13:0] offset;
      logic        typed;
      logic [1:0]  status;
      logic [13:0] data_offset;
   } stim_row_t;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [14:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_mode;
   logic [14:0] req_request_bytes;
   logic [13:0] req_release_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   alloc_rsp_t  rsp;

   first_fit_heap_allocator_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_mode               (req_mode),
      .req_request_bytes      (req_request_bytes),
      .req_release_offset     (req_release_offset),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp.status),
      .rsp_data_offset        (rsp.data_offset),
      .rsp_free_bytes         (rsp.free_bytes),
      .rsp_largest_free       (rsp.largest_free),
      .rsp_free_blocks        (rsp.free_blocks),
      .rsp_used_blocks        (rsp.used_blocks),
      .rsp_percent_used       (rsp.percent_used),
      .rsp_percent_fragmented (rsp.percent_fragmented)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the allocator: header words, latched pool size, the
   // formatted flag and the two configuration registers.
   int unsigned heap_hdr[POOL_WORDS];
   int unsigned heap_total;
   bit          heap_formatted;
   int unsigned cfg_pool_bytes;
   bit          cfg_merge;

   // Data offsets handed out and not yet released, used to build frees.
   int unsigned live_offsets[$];
   alloc_rsp_t  pending_rsp[$];

   int  error_count;
   int  sent_count;
   int  rsp_count;
   int  alloc_ok_count;
   bit  quiet;

   function automatic int unsigned hdr_rd(int unsigned off);
      return heap_hdr[(off >> 2) % POOL_WORDS];
   endfunction

   function automatic void hdr_wr(int unsigned off, int unsigned v);
      heap_hdr[(off >> 2) % POOL_WORDS] = v;
   endfunction

   // A following block exists only if its data would start before pool end.
   function automatic bit chain_next(int unsigned off, output int unsigned nx);
      int unsigned n;
      n = off + HDR_SPAN + (hdr_rd(off) & SIZE_BITS);
      nx = n;
      return !(n >= heap_total || heap_total - n <= HDR_SPAN);
   endfunction

   // Merges the run of free blocks after off into it. Returns the first used
   // block that stopped the run, or reports that the chain ended.
   function automatic int unsigned merge_run(int unsigned off, output bit ended);
      int unsigned h;
      int unsigned cur;
      int unsigned n;
      h = hdr_rd(off);
      cur = off;
      ended = 1'b0;
      while (chain_next(cur, n)) begin
         if (hdr_rd(n) & USED_FLAG)
            return n;
         h = (h & USED_FLAG) |
             (((h & SIZE_BITS) + (hdr_rd(n) & SIZE_BITS) + HDR_SPAN) & SIZE_BITS);
         hdr_wr(off, h);
         cur = n;
      end
      ended = 1'b1;
      return 0;
   endfunction

   function automatic alloc_rsp_t heap_apply(logic [2:0] mode, logic [14:0] bytes,
                                             logic [13:0] rel);
      alloc_rsp_t  r;
      int unsigned off, n, h, sz, have, target, p;
      int unsigned fb, big, cf, cu;
      bit          ended, found, any;
      r = '0;
      case (mode)
         MODE_FORMAT: begin
            p = cfg_pool_bytes & ~32'd3;
            if (p > POOL_BYTES) p = POOL_BYTES;
            if (p < HDR_SPAN) p = HDR_SPAN;
            heap_total = p;
            heap_formatted = 1'b1;
            hdr_wr(0, p - HDR_SPAN);
            live_offsets.delete();
         end
         MODE_ALLOC: begin
            if (bytes == 0) begin
               r.status = STATUS_ZERO;
            end else if (!heap_formatted) begin
               r.status = STATUS_NOFIT;
            end else begin
               sz = (int'(bytes) + 3) & ~32'd3;
               found = 1'b0;
               off = 0;
               forever begin
                  h = hdr_rd(off);
                  if (!(h & USED_FLAG) && (h & SIZE_BITS) >= sz) begin
                     have = h & SIZE_BITS;
                     // The remainder is split off only if it can hold data.
                     if (have - sz > HDR_SPAN) begin
                        hdr_wr(off + HDR_SPAN + sz, have - sz - HDR_SPAN);
                        have = sz;
                     end
                     hdr_wr(off, USED_FLAG | have);
                     r.data_offset = 14'(off + HDR_SPAN);
                     found = 1'b1;
                     break;
                  end
                  if (!chain_next(off, n)) break;
                  off = n;
               end
               r.status = found ? STATUS_OK : STATUS_NOFIT;
               if (found) live_offsets.push_back(r.data_offset);
            end
         end
         MODE_FREE: begin
            if (heap_formatted && rel >= HDR_SPAN) begin
               target = rel - HDR_SPAN;
               off = 0;
               forever begin
                  if (off == target) begin
                     hdr_wr(off, hdr_rd(off) & SIZE_BITS);
                     if (cfg_merge) void'(merge_run(off, ended));
                     break;
                  end
                  if (off > target || !chain_next(off, n)) break;
                  off = n;
               end
            end
         end
         MODE_DEFRAG: begin
            if (heap_formatted) begin
               off = 0;
               forever begin
                  any = 1'b1;
                  while (hdr_rd(off) & USED_FLAG) begin
                     if (!chain_next(off, n)) begin
                        any = 1'b0;
                        break;
                     end
                     off = n;
                  end
                  if (!any) break;
                  n = merge_run(off, ended);
                  if (ended) break;
                  off = n;
               end
            end
         end
         MODE_REPORT: begin
            if (heap_formatted) begin
               fb = 0; big = 0; cf = 0; cu = 0;
               off = 0;
               forever begin
                  h = hdr_rd(off);
                  if (h & USED_FLAG) begin
                     cu++;
                  end else begin
                     cf++;
                     fb += h & SIZE_BITS;
                     if ((h & SIZE_BITS) > big) big = h & SIZE_BITS;
                  end
                  if (!chain_next(off, n)) break;
                  off = n;
               end
               r.free_bytes = 15'(fb);
               r.largest_free = 15'(big);
               r.free_blocks = 13'(cf);
               r.used_blocks = 13'(cu);
               r.percent_used = 7'(100 - (longint'(fb) * 100) / heap_total);
               // With nothing free the fragmentation reads zero.
               r.percent_fragmented = (fb != 0) ?
                                      7'(100 - (longint'(big) * 100) / fb) : 7'd0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Receiver: stalls about 23 times in a hundred unless a quiet stretch runs.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 23);
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: mismatch on %s, expected %0d, actual %0d",
                  $time, name, want, got);
         error_count++;
      end
   endtask

   // Every accepted response transaction is checked against the oldest
   // prediction still waiting.
   always @(posedge clock) begin
      alloc_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $display("%0t ns: response with nothing expected, status %0d", $time,
                     rsp.status);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", want.status, rsp.status);
            check_field("data_offset", want.data_offset, rsp.data_offset);
            check_field("free_bytes", want.free_bytes, rsp.free_bytes);
            check_field("largest_free", want.largest_free, rsp.largest_free);
            check_field("free_blocks", want.free_blocks, rsp.free_blocks);
            check_field("used_blocks", want.used_blocks, rsp.used_blocks);
            check_field("percent_used", want.percent_used, rsp.percent_used);
            check_field("percent_fragmented", want.percent_fragmented,
                        rsp.percent_fragmented);
         end
      end
   end

   // Sender gap: about 23 times in a hundred, valid drops for a random wait first.
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Presents one request transaction and holds it until it is accepted. The
   // prediction is made at the accepting edge; a typed expectation replaces
   // it where one is given, while the shadow state still advances.
   task automatic send_req(logic [2:0] mode, logic [14:0] bytes, logic [13:0] rel,
                           bit typed = 1'b0, alloc_rsp_t typed_rsp = '0);
      alloc_rsp_t pred;
      sender_gap();
      req_valid <= 1'b1;
      req_mode <= mode;
      req_request_bytes <= bytes;
      req_release_offset <= rel;
      do @(posedge clock); while (req_stall);
      pred = heap_apply(mode, bytes, rel);
      if (mode == MODE_ALLOC && pred.status == STATUS_OK) alloc_ok_count++;
      pending_rsp.push_back(typed ? typed_rsp : pred);
      sent_count++;
   endtask

   // Waits until every predicted response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [14:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_POOL_BYTES)
         cfg_pool_bytes = value;
      else
         cfg_merge = value[0];
   endtask

   // One random transaction. Most are well-formed allocates and frees of
   // live blocks so the chain grows deep; the rest are reports, defragments and noise.
   task automatic random_req();
      int unsigned pick, idx, off;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         if ($urandom_range(0, 9) == 0)
            send_req(MODE_ALLOC, 15'($urandom_range(65, 2048)), 14'($urandom));
         else
            send_req(MODE_ALLOC, 15'($urandom_range(1, 64)), 14'($urandom));
      end else if (pick < 70 && live_offsets.size() != 0) begin
         idx = $urandom_range(0, live_offsets.size() - 1);
         off = live_offsets[idx];
         live_offsets.delete(idx);
         send_req(MODE_FREE, 15'($urandom), 14'(off));
      end else if (pick < 82) begin
         send_req(MODE_REPORT, 15'($urandom), 14'($urandom));
      end else if (pick < 90) begin
         send_req(MODE_DEFRAG, 15'($urandom), 14'($urandom));
      end else begin
         case ($urandom_range(0, 3))
            0: send_req(MODE_ALLOC, 15'($urandom_range(0, 32767)), 14'($urandom));
            1: send_req(MODE_FREE, 15'($urandom), 14'($urandom_range(0, 16383)));
            2: send_req(3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI)),
                        15'($urandom), 14'($urandom));
            default: send_req(MODE_ALLOC, 15'd0, 14'($urandom));
         endcase
      end
   endtask

   initial begin
      stim_row_t   dir_tab[$];
      alloc_rsp_t  typed_rsp;
      int unsigned phase_pool[5];
      bit          phase_merge[5];

      quiet = 1'b0;
      error_count = 0;
      sent_count = 0;
      rsp_count = 0;
      alloc_ok_count = 0;
      heap_total = 0;
      heap_formatted = 1'b0;
      cfg_pool_bytes = POOL_BYTES;
      cfg_merge = 1'b1;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_POOL_BYTES;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_mode = MODE_REPORT;
      req_request_bytes = '0;
      req_release_offset = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Rows flagged as typed carry an answer that is plain
      // from the rules: unformatted pool, zero size, undefined modes, the
      // format itself, the first allocate after it, two oversized requests.
      dir_tab = '{
         '{MODE_REPORT,   15'd0,     14'd0,     1'b1, STATUS_OK,    14'd0},
         '{MODE_ALLOC,    15'd8,     14'd0,     1'b1, STATUS_NOFIT, 14'd0},
         '{MODE_ALLOC,    15'd0,     14'd0,     1'b1, STATUS_ZERO,  14'd0},
         '{MODE_FREE,     15'd0,     14'd4,     1'b1, STATUS_OK,    14'd0},
         '{MODE_DEFRAG,   15'd0,     14'd0,     1'b1, STATUS_OK,    14'd0},
         '{MODE_UNDEF_LO, 15'd0,     14'd0,     1'b1, STATUS_OK,    14'd0},
         '{MODE_FORMAT,   15'd0,     14'd0,     1'b1, STATUS_OK,    14'd0},
         '{MODE_ALLOC,    15'd1,     14'd0,     1'b1, STATUS_OK,    14'd4},
         '{MODE_ALLOC,    15'd16384, 14'd0,     1'b1, STATUS_NOFIT, 14'd0},
         '{MODE_ALLOC,    15'h7FFF,  14'h3FFF,  1'b1, STATUS_NOFIT, 14'd0},
         '{MODE_ALLOC,    15'd5,     14'd0,     1'b0, STATUS_OK,    14'd0},
         '{MODE_ALLOC,    15'd13,    14'd0,     1'b0, STATUS_OK,    14'd0},
         '{MODE_REPORT,   15'd0,     14'd0,     1'b0, STATUS_OK,    14'd0},
         '{MODE_FREE,     15'd0,     14'd4,     1'b0, STATUS_OK,    14'd0},
         '{MODE_FREE,     15'd0,     14'd3,     1'b0, STATUS_OK,    14'd0},
         '{MODE_FREE,     15'd0,     14'd6,     1'b0, STATUS_OK,    14'd0},
         '{MODE_FREE,     15'd0,     14'd4,     1'b0, STATUS_OK,    14'd0},
         '{MODE_FREE,     15'd0,     14'd16380, 1'b0, STATUS_OK,    14'd0},
         '{MODE_DEFRAG,   15'd0,     14'd0,     1'b0, STATUS_OK,    14'd0},
         '{MODE_ALLOC,    15'd16300, 14'd0,     1'b0, STATUS_OK,    14'd0},
         '{MODE_ALLOC,    15'd60,    14'd0,     1'b0, STATUS_OK,    14'd0},
         '{MODE_REPORT,   15'd0,     14'd0,     1'b0, STATUS_OK,    14'd0},
         '{MODE_UNDEF_HI, 15'h7FFF,  14'h3FFF,  1'b1, STATUS_OK,    14'd0}
      };
      foreach (dir_tab[i]) begin
         typed_rsp = '0;
         typed_rsp.status = dir_tab[i].status;
         typed_rsp.data_offset = dir_tab[i].data_offset;
         send_req(dir_tab[i].mode, dir_tab[i].bytes, dir_tab[i].offset,
                  dir_tab[i].typed, typed_rsp);
      end
      drain();

      // Random part in phases, each under its own pool size and merge mode.
      // The pool sizes include one of eight bytes and one that saturates.
      phase_pool = '{16384, 8, 60, 32767, 0};
      phase_merge = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      phase_pool[4] = $urandom_range(100, 800);
      phase_merge[4] = 1'($urandom_range(0, 1));
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CSR_POOL_BYTES, 15'(phase_pool[ph]));
         csr_write(CSR_MERGE_ON_FREE, 15'(phase_merge[ph]));
         quiet = (ph == 2);
         send_req(MODE_FORMAT, 15'($urandom), 14'($urandom));
         for (int k = 0; k < 54; k++) begin
            // Once, hold the sender until everything in flight has answered.
            if (ph == 0 && k == 25) drain();
            random_req();
         end
         drain();
      end
      quiet = 1'b0;

      repeat (50) @(posedge clock);
      $display("Ran %0d requests with %0d responses, %0d successful allocates,",
               sent_count, rsp_count, alloc_ok_count);
      $display("over five pool settings with merge on free both on and off.");
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/ffha_div.sv
hdl/ffha_datapath.sv
hdl/ffha_ctrl.sv
hdl/first_fit_heap_allocator_unit.sv
test/first_fit_heap_allocator_unit_tb.sv
